@@ hdl/tucc_pkg.sv @@
// ----------------------------------------------------------------------------
// tucc_pkg
// Types and constants shared by the thermostat command controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tucc_pkg;

  typedef struct packed {
    logic              kind;
    logic [7:0]        rx_byte;
    logic signed [7:0] temperature;
  } in_t;

  typedef enum logic [1:0] {
    MODE_CMD   = 2'd0,
    MODE_ENTRY = 2'd1,
    MODE_MENU  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    TGT_UPPER = 2'd0,
    TGT_LOWER = 2'd1,
    TGT_DIM   = 2'd2
  } target_t;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_APPLIED   = 4'd1,
    ST_PROMPT    = 4'd2,
    ST_MENU      = 4'd3,
    ST_BAD_CMD   = 4'd4,
    ST_ACCEPTED  = 4'd5,
    ST_RANGE     = 4'd6,
    ST_EMPTY     = 4'd7,
    ST_TOO_LONG  = 4'd8,
    ST_BAD_CHAR  = 4'd9,
    ST_BAD_MENU  = 4'd10,
    ST_DIGIT     = 4'd11
  } status_t;

  typedef struct packed {
    logic              over_limit_led;
    logic              under_limit_led;
    logic              report_now;
    logic signed [7:0] temperature_out;
    logic [5:0]        upper_threshold;
    logic [5:0]        lower_threshold;
    logic [6:0]        dim_percent;
    logic [15:0]       pwm_compare;
    mode_t             entry_mode;
    status_t           status;
  } out_t;

  // classified item passed from front to back
  typedef enum logic [3:0] {
    OP_TICK,
    OP_UP_ENTRY,
    OP_LO_ENTRY,
    OP_MENU,
    OP_DIM_UP,
    OP_DIM_DN,
    OP_UP_INC,
    OP_UP_DEC,
    OP_LO_INC,
    OP_LO_DEC,
    OP_CR,
    OP_DIGIT,
    OP_OTHER
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [3:0]        digit;
    logic signed [7:0] temperature;
  } item_t;

  localparam logic [7:0] CH_X  = 8'h78;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_M  = 8'h6D;
  localparam logic [7:0] CH_C  = 8'h63;
  localparam logic [7:0] CH_Z  = 8'h7A;
  localparam logic [7:0] CH_D  = 8'h64;
  localparam logic [7:0] CH_A  = 8'h61;
  localparam logic [7:0] CH_W  = 8'h77;
  localparam logic [7:0] CH_S  = 8'h73;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;

  localparam logic [5:0] UPPER_MAX   = 6'd50;
  localparam logic [6:0] DIM_MAX     = 7'd100;
  localparam logic [6:0] DIM_INCR    = 7'd10;
  localparam logic [5:0] UPPER_RESET = 6'd35;
  localparam logic [5:0] LOWER_RESET = 6'd25;
  localparam logic [6:0] DIM_RESET   = 7'd50;

  localparam logic [15:0] PERIOD_RESET   = 16'd2400;
  localparam logic [7:0]  INTERVAL_RESET = 8'd5;

  localparam logic REG_PERIOD          = 1'b0;
  localparam logic REG_REPORT_INTERVAL = 1'b1;

  // floor(p/100) = (p * RECIP) >> RECIP_SHIFT, exact for p < 2^23
  localparam logic [23:0] RECIP       = 24'd10737419;
  localparam int          RECIP_SHIFT = 30;

endpackage

`default_nettype wire

@@ hdl/thermostat_uart_command_controller_core.sv @@
// ----------------------------------------------------------------------------
// thermostat_uart_command_controller_core
// Path from input transfer to result valid: queue, command machine, result register,
//   multiply, divide by 100, output register; out_ready can stall the pipeline.
// Throughput: one item per cycle while the result pipeline is not stalled.
// Reset (rst, synchronous): queue and pipeline empty, command mode, upper 35,
//   lower 25, dim 50, PWM period 2400, report interval 5.
// ----------------------------------------------------------------------------
`default_nettype none

module thermostat_uart_command_controller_core #(
  parameter int MAX_DIGITS = 10,
  parameter int QDEPTH     = 2
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tucc_pkg::in_t   in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tucc_pkg::out_t       out_data,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0]     period_counts;
  logic [7:0]      report_interval;
  logic            push, pop, full, empty;
  tucc_pkg::item_t fr_item, q_item;
  logic            res_valid, res_ready;
  tucc_pkg::out_t  res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tucc_pkg::REG_REPORT_INTERVAL) ? {24'd0, report_interval}
                                                              : {16'd0, period_counts};

  always_ff @(posedge clk) begin
    if (rst) begin
      period_counts   <= tucc_pkg::PERIOD_RESET;
      report_interval <= tucc_pkg::INTERVAL_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == tucc_pkg::REG_PERIOD) begin
        period_counts <= pwdata[15:0];
      end else begin
        report_interval <= pwdata[7:0];
      end
    end
  end

  tucc_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .full     (full),
    .push     (push),
    .item     (fr_item)
  );

  tucc_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (fr_item),
    .pop   (pop),
    .rdata (q_item),
    .full  (full),
    .empty (empty)
  );

  tucc_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .report_interval (report_interval),
    .empty           (empty),
    .item            (q_item),
    .pop             (pop),
    .res_valid       (res_valid),
    .res_ready       (res_ready),
    .res             (res)
  );

  tucc_pwm u_pwm (
    .clk           (clk),
    .rst           (rst),
    .period_counts (period_counts),
    .in_valid      (res_valid),
    .in_ready      (res_ready),
    .in_res        (res),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

  a_thresh_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.lower_threshold < out_data.upper_threshold)
    else $error("lower threshold not below upper threshold");

  a_limits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.upper_threshold <= tucc_pkg::UPPER_MAX) &&
                  (out_data.dim_percent <= tucc_pkg::DIM_MAX))
    else $error("threshold or dimming out of range");

  a_report_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.report_now |-> out_data.status == tucc_pkg::ST_NONE)
    else $error("report raised on a byte transfer");

  a_no_report_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.report_now |-> out_data.temperature_out == 8'sd0)
    else $error("temperature shown without report");

endmodule

`default_nettype wire

@@ hdl/tucc_front.sv @@
// ----------------------------------------------------------------------------
// tucc_front
// Accepts input items and decodes them into queue entries.
// ----------------------------------------------------------------------------
`default_nettype none

module tucc_front (
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tucc_pkg::in_t   in_data,
  input  wire logic            full,
  output logic                 push,
  output tucc_pkg::item_t      item
);

  assign in_ready = !full;
  assign push     = in_valid && !full;

  always_comb begin
    item.temperature = in_data.temperature;
    item.digit       = in_data.rx_byte[3:0];
    if (!in_data.kind) begin
      item.op = tucc_pkg::OP_TICK;
    end else begin
      unique case (in_data.rx_byte)
        tucc_pkg::CH_X:  item.op = tucc_pkg::OP_UP_ENTRY;
        tucc_pkg::CH_N:  item.op = tucc_pkg::OP_LO_ENTRY;
        tucc_pkg::CH_M:  item.op = tucc_pkg::OP_MENU;
        tucc_pkg::CH_C:  item.op = tucc_pkg::OP_DIM_UP;
        tucc_pkg::CH_Z:  item.op = tucc_pkg::OP_DIM_DN;
        tucc_pkg::CH_D:  item.op = tucc_pkg::OP_UP_INC;
        tucc_pkg::CH_A:  item.op = tucc_pkg::OP_UP_DEC;
        tucc_pkg::CH_W:  item.op = tucc_pkg::OP_LO_INC;
        tucc_pkg::CH_S:  item.op = tucc_pkg::OP_LO_DEC;
        tucc_pkg::CH_CR: item.op = tucc_pkg::OP_CR;
        default: begin
          if (in_data.rx_byte >= tucc_pkg::CH_0 && in_data.rx_byte <= tucc_pkg::CH_9) begin
            item.op = tucc_pkg::OP_DIGIT;
          end else begin
            item.op = tucc_pkg::OP_OTHER;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hdl/tucc_fifo.sv @@
// ----------------------------------------------------------------------------
// tucc_fifo
// Short queue of decoded items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module tucc_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire tucc_pkg::item_t  wdata,
  input  wire logic             pop,
  output tucc_pkg::item_t       rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  tucc_pkg::item_t mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/tucc_back.sv @@
// ----------------------------------------------------------------------------
// tucc_back
// Command machine, value entry, alarms and report phase; one item per cycle while res_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module tucc_back #(
  parameter int MAX_DIGITS = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       report_interval,
  input  wire logic             empty,
  input  wire tucc_pkg::item_t  item,
  output logic                  pop,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output tucc_pkg::out_t        res
);

  localparam int DCW = $clog2(MAX_DIGITS + 1);

  tucc_pkg::mode_t   mode, mode_next;
  tucc_pkg::target_t target, target_next;
  logic [DCW-1:0]    count, count_next;
  logic [15:0]       value, value_next;
  logic [5:0]        upper, upper_next;
  logic [5:0]        lower, lower_next;
  logic [6:0]        dim, dim_next;
  logic              paused, paused_next;
  logic [7:0]        phase, phase_next;
  logic              over, over_next;
  logic              under, under_next;

  tucc_pkg::status_t status;
  logic              report;
  logic              ok;
  logic [15:0]       base;
  logic [19:0]       acc;
  logic [8:0]        phase_inc;
  logic [7:0]        interval;

  assign pop       = !empty && res_ready;
  assign res_valid = !empty;

  assign base      = (count == '0) ? 16'd0 : value;
  assign acc       = ({4'd0, base} << 3) + ({4'd0, base} << 1) + {16'd0, item.digit};
  assign phase_inc = {1'b0, phase} + 9'd1;
  assign interval  = (report_interval == 8'd0) ? 8'd1 : report_interval;

  always_comb begin
    unique case (target)
      tucc_pkg::TGT_UPPER: ok = (value <= 16'(tucc_pkg::UPPER_MAX)) && (value > 16'(lower));
      tucc_pkg::TGT_LOWER: ok = (value < 16'(upper));
      tucc_pkg::TGT_DIM:   ok = (value <= 16'(tucc_pkg::DIM_MAX));
      default:             ok = 1'b0;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    target_next = target;
    count_next  = count;
    value_next  = value;
    upper_next  = upper;
    lower_next  = lower;
    dim_next    = dim;
    paused_next = paused;
    phase_next  = phase;
    over_next   = over;
    under_next  = under;
    status      = tucc_pkg::ST_NONE;
    report      = 1'b0;

    if (item.op == tucc_pkg::OP_TICK) begin
      over_next  = item.temperature > $signed({2'b00, upper});
      under_next = item.temperature < $signed({2'b00, lower});
      report     = !paused && (phase == 8'd0);
      phase_next = (phase_inc >= {1'b0, interval}) ? 8'd0 : phase_inc[7:0];
    end else begin
      unique case (mode)
        tucc_pkg::MODE_CMD: begin
          unique case (item.op)
            tucc_pkg::OP_UP_ENTRY, tucc_pkg::OP_LO_ENTRY: begin
              target_next = (item.op == tucc_pkg::OP_UP_ENTRY) ? tucc_pkg::TGT_UPPER
                                                               : tucc_pkg::TGT_LOWER;
              mode_next   = tucc_pkg::MODE_ENTRY;
              paused_next = 1'b1;
              count_next  = '0;
              value_next  = '0;
              status      = tucc_pkg::ST_PROMPT;
            end
            tucc_pkg::OP_MENU: begin
              mode_next   = tucc_pkg::MODE_MENU;
              paused_next = 1'b1;
              status      = tucc_pkg::ST_MENU;
            end
            tucc_pkg::OP_DIM_UP: begin
              dim_next = (dim > tucc_pkg::DIM_MAX - tucc_pkg::DIM_INCR) ? tucc_pkg::DIM_MAX
                                                                       : dim + tucc_pkg::DIM_INCR;
              status   = tucc_pkg::ST_APPLIED;
            end
            tucc_pkg::OP_DIM_DN: begin
              dim_next = (dim < tucc_pkg::DIM_INCR) ? 7'd0 : dim - tucc_pkg::DIM_INCR;
              status   = tucc_pkg::ST_APPLIED;
            end
            tucc_pkg::OP_UP_INC: begin
              if (upper < tucc_pkg::UPPER_MAX) begin
                upper_next = upper + 6'd1;
              end
              status = tucc_pkg::ST_APPLIED;
            end
            tucc_pkg::OP_UP_DEC: begin
              if ({1'b0, upper} > {1'b0, lower} + 7'd1) begin
                upper_next = upper - 6'd1;
              end
              status = tucc_pkg::ST_APPLIED;
            end
            tucc_pkg::OP_LO_INC: begin
              if ({1'b0, lower} + 7'd1 < {1'b0, upper}) begin
                lower_next = lower + 6'd1;
              end
              status = tucc_pkg::ST_APPLIED;
            end
            tucc_pkg::OP_LO_DEC: begin
              if (lower != 6'd0) begin
                lower_next = lower - 6'd1;
              end
              status = tucc_pkg::ST_APPLIED;
            end
            default: begin
              status = tucc_pkg::ST_BAD_CMD;
            end
          endcase
        end
        tucc_pkg::MODE_ENTRY: begin
          priority if (item.op == tucc_pkg::OP_CR) begin
            if (count == '0) begin
              status = tucc_pkg::ST_EMPTY;
            end else begin
              count_next = '0;
              value_next = '0;
              if (ok) begin
                unique case (target)
                  tucc_pkg::TGT_UPPER: upper_next = value[5:0];
                  tucc_pkg::TGT_LOWER: lower_next = value[5:0];
                  default:             dim_next   = value[6:0];
                endcase
                mode_next   = tucc_pkg::MODE_CMD;
                paused_next = 1'b0;
                status      = tucc_pkg::ST_ACCEPTED;
              end else begin
                status = tucc_pkg::ST_RANGE;
              end
            end
          end else if (item.op == tucc_pkg::OP_DIGIT) begin
            if (count >= DCW'(MAX_DIGITS)) begin
              count_next = '0;
              value_next = '0;
              status     = tucc_pkg::ST_TOO_LONG;
            end else begin
              value_next = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
              count_next = count + 1'b1;
              status     = tucc_pkg::ST_DIGIT;
            end
          end else begin
            count_next = '0;
            value_next = '0;
            status     = tucc_pkg::ST_BAD_CHAR;
          end
        end
        tucc_pkg::MODE_MENU: begin
          if (item.op == tucc_pkg::OP_DIGIT && item.digit >= 4'd1 && item.digit <= 4'd3) begin
            target_next = tucc_pkg::target_t'(2'(item.digit - 4'd1));
            mode_next   = tucc_pkg::MODE_ENTRY;
            paused_next = 1'b1;
            count_next  = '0;
            value_next  = '0;
            status      = tucc_pkg::ST_PROMPT;
          end else begin
            status = tucc_pkg::ST_BAD_MENU;
          end
        end
        default: begin
          mode_next = tucc_pkg::MODE_CMD;
        end
      endcase
    end

    res.over_limit_led  = over_next;
    res.under_limit_led = under_next;
    res.report_now      = report;
    res.temperature_out = report ? item.temperature : 8'sd0;
    res.upper_threshold = upper_next;
    res.lower_threshold = lower_next;
    res.dim_percent     = dim_next;
    res.pwm_compare     = '0;
    res.entry_mode      = mode_next;
    res.status          = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= tucc_pkg::MODE_CMD;
      target <= tucc_pkg::TGT_UPPER;
      count  <= '0;
      value  <= '0;
      upper  <= tucc_pkg::UPPER_RESET;
      lower  <= tucc_pkg::LOWER_RESET;
      dim    <= tucc_pkg::DIM_RESET;
      paused <= 1'b0;
      phase  <= '0;
      over   <= 1'b0;
      under  <= 1'b0;
    end else if (pop) begin
      mode   <= mode_next;
      target <= target_next;
      count  <= count_next;
      value  <= value_next;
      upper  <= upper_next;
      lower  <= lower_next;
      dim    <= dim_next;
      paused <= paused_next;
      phase  <= phase_next;
      over   <= over_next;
      under  <= under_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/tucc_pwm.sv @@
// ----------------------------------------------------------------------------
// tucc_pwm
// Result pipeline: input register, dim * period, divide by 100, compare value, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tucc_pwm (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic [15:0]     period_counts,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tucc_pkg::out_t  in_res,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tucc_pkg::out_t       out_data
);

  logic           v1, v2, v3;
  logic           rdy1, rdy2, rdy3, rdy_o;
  tucc_pkg::out_t r1, r2, r3;
  tucc_pkg::out_t res_out;
  logic [22:0]    prod;
  logic [15:0]    quot;
  logic [46:0]    scaled;

  assign rdy_o    = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy_o;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign scaled = {24'd0, prod} * {23'd0, tucc_pkg::RECIP};

  always_comb begin
    res_out             = r3;
    res_out.pwm_compare = (quot == 16'd0) ? 16'd0 : quot - 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      r1 <= in_res;
    end
    if (rdy2) begin
      r2   <= r1;
      prod <= 23'({16'd0, r1.dim_percent} * {7'd0, period_counts});
    end
    if (rdy3) begin
      r3   <= r2;
      quot <= scaled[tucc_pkg::RECIP_SHIFT +: 16];
    end
    if (rdy_o) begin
      out_data <= res_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_o) begin
        out_valid <= v3;
      end
    end
  end

endmodule

`default_nettype wire
